// File: rtl/hsl2rgb_pkg.sv
// Shared types and defaults for the HSL to RGB converter.
// No dependencies; used by hsl2rgb_channel and hsl_to_rgb_converter.
package hsl2rgb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int HUE_STEPS_DEF = 360;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } t_hsl_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_out;

    // Hue rotation applied ahead of one channel's transfer function
    typedef enum logic [1:0] {
        HUE_SHIFT_NONE,
        HUE_SHIFT_UP,
        HUE_SHIFT_DOWN
    } t_hue_shift;

endpackage

// File: rtl/hsl2rgb_channel.sv
// One output channel: hue rotation and wrap, piecewise-linear level, byte scaling.
// Four register stages, free running. Depends on hsl2rgb_pkg.
module hsl2rgb_channel #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  hsl2rgb_pkg::t_hue_shift   i_shift,
    input  logic [FRAC_BITS-1:0]      i_hue,
    input  logic signed [FRAC_BITS+4:0] i_v1,
    input  logic [FRAC_BITS+1:0]      i_d,
    input  logic                      i_gray,
    input  logic [7:0]                i_lit,
    output logic [7:0]                o_level
);

    localparam int F  = FRAC_BITS;
    localparam int CW = F + 5;      // signed level width
    localparam int MW = F + 3;      // ramp factor width
    localparam int AW = F + 5;      // addend width

    localparam logic signed [CW-1:0] C_ONE   = CW'(64'd1 << F);
    localparam logic signed [CW-1:0] C_THIRD = CW'((64'd1 << F) / 3);
    localparam logic [F+3:0] K_ONE4     = (F+4)'(64'd1 << F);
    localparam logic [F+3:0] K_TWO_ONE4 = (F+4)'(64'd2 << F);
    localparam logic [F:0]   K_TWO_THIRDS = (F+1)'((64'd2 << F) / 3);

    typedef enum logic [1:0] {
        REG_RISE,
        REG_HIGH,
        REG_FALL,
        REG_LOW
    } t_region;

    // ---------------- stage E: rotate and wrap hue
    logic signed [CW-1:0] w_hue_s;
    logic signed [CW-1:0] w_t_raw;
    logic signed [CW-1:0] w_t_wrap;
    logic [F:0]           n_e_t;

    logic [F:0]           r_e_t;
    logic signed [CW-1:0] r_e_v1;
    logic [F+1:0]         r_e_d;
    logic                 r_e_gray;
    logic [7:0]           r_e_lit;

    assign w_hue_s = $signed(CW'(i_hue));

    always_comb begin
        case (i_shift)
            hsl2rgb_pkg::HUE_SHIFT_UP:   w_t_raw = w_hue_s + C_THIRD;
            hsl2rgb_pkg::HUE_SHIFT_DOWN: w_t_raw = w_hue_s - C_THIRD;
            default:                     w_t_raw = w_hue_s;
        endcase
        // t equal to one stays one
        if (w_t_raw[CW-1]) begin
            w_t_wrap = w_t_raw + C_ONE;
        end else if (w_t_raw > C_ONE) begin
            w_t_wrap = w_t_raw - C_ONE;
        end else begin
            w_t_wrap = w_t_raw;
        end
        n_e_t = w_t_wrap[F:0];
    end

    always_ff @(posedge i_clk) begin
        r_e_t    <= n_e_t;
        r_e_v1   <= i_v1;
        r_e_d    <= i_d;
        r_e_gray <= i_gray;
        r_e_lit  <= i_lit;
    end

    // ---------------- stage F: region and ramp factor
    logic [F+3:0] w_t4;
    logic [F+3:0] w_six_t;
    logic [F+3:0] w_three_t;
    logic [F+3:0] w_two_t;
    logic [F:0]   w_fall;
    logic [F+3:0] w_six_fall;
    t_region      n_f_region;
    logic [MW-1:0] n_f_m;

    t_region              r_f_region;
    logic [MW-1:0]        r_f_m;
    logic signed [CW-1:0] r_f_v1;
    logic [F+1:0]         r_f_d;
    logic                 r_f_gray;
    logic [7:0]           r_f_lit;

    always_comb begin
        w_t4       = {3'b000, r_e_t};
        w_six_t    = (w_t4 << 2) + (w_t4 << 1);
        w_three_t  = w_t4 + (w_t4 << 1);
        w_two_t    = w_t4 << 1;
        w_fall     = K_TWO_THIRDS - r_e_t;
        w_six_fall = ({3'b000, w_fall} << 2) + ({3'b000, w_fall} << 1);
        if (w_six_t < K_ONE4) begin
            n_f_region = REG_RISE;
            n_f_m      = w_six_t[MW-1:0];
        end else if (w_two_t < K_ONE4) begin
            n_f_region = REG_HIGH;
            n_f_m      = '0;
        end else if (w_three_t < K_TWO_ONE4) begin
            n_f_region = REG_FALL;
            n_f_m      = w_six_fall[MW-1:0];
        end else begin
            n_f_region = REG_LOW;
            n_f_m      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_region <= n_f_region;
        r_f_m      <= n_f_m;
        r_f_v1     <= r_e_v1;
        r_f_d      <= r_e_d;
        r_f_gray   <= r_e_gray;
        r_f_lit    <= r_e_lit;
    end

    // ---------------- stage G: ramp multiply, addend select
    logic [2*F+4:0] w_prod;
    logic [AW-1:0]  n_g_add;

    logic [AW-1:0]        r_g_add;
    logic signed [CW-1:0] r_g_v1;
    logic                 r_g_gray;
    logic [7:0]           r_g_lit;

    assign w_prod = r_f_d * r_f_m;

    always_comb begin
        case (r_f_region)
            REG_RISE: n_g_add = w_prod[2*F+4:F];
            REG_FALL: n_g_add = w_prod[2*F+4:F];
            REG_HIGH: n_g_add = AW'(r_f_d);     // v2 = v1 + d
            default:  n_g_add = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_g_add  <= n_g_add;
        r_g_v1   <= r_f_v1;
        r_g_gray <= r_f_gray;
        r_g_lit  <= r_f_lit;
    end

    // ---------------- stage H: level to byte
    logic signed [F+5:0] w_c;
    logic [F+4:0]        w_cu;
    logic [F+12:0]       w_scaled;
    logic [12:0]         w_v;
    logic [7:0]          w_byte;
    logic [7:0]          n_level;

    always_comb begin
        w_c      = $signed({r_g_v1[CW-1], r_g_v1}) + $signed({1'b0, r_g_add});
        w_cu     = w_c[F+4:0];
        w_scaled = {w_cu, 8'h00} - {8'h00, w_cu};
        w_v      = w_scaled[F+12:F];
        if (w_c[F+5] || (w_c == '0)) begin
            w_byte = 8'h00;
        end else if (|w_v[12:8]) begin
            w_byte = 8'hFF;
        end else begin
            w_byte = w_v[7:0];
        end
        n_level = r_g_gray ? r_g_lit : w_byte;
    end

    always_ff @(posedge i_clk) begin
        o_level <= n_level;
    end

endmodule

// File: rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: hue reduction, fixed-point scaling, levels.
// Depends on hsl2rgb_pkg and hsl2rgb_channel.
//
// One HSL color is taken on every clock in which start is high; busy is never
// raised. The matching RGB result appears on o_result with o_valid high for one
// cycle, in request order, after passing through the pipeline. The pipeline is
// 8 register stages (4 here for hue reduction, fraction scaling and the two
// levels, 4 in each channel unit), sustained rate one color per clock. The
// receiver cannot stall results; it must take each one in its o_valid cycle.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF,
    parameter int HUE_STEPS = hsl2rgb_pkg::HUE_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  hsl2rgb_pkg::t_hsl_in  i_request,
    output logic                  busy,
    output logic                  o_valid,
    output hsl2rgb_pkg::t_rgb_out o_result
);

    localparam int F   = FRAC_BITS;
    localparam int HW  = $clog2(HUE_STEPS);
    localparam int KH  = 9 + HW;
    localparam int CW  = F + 5;
    localparam int LAT = 8;

    localparam logic [12:0]  N13 = 13'(HUE_STEPS);
    localparam logic [9:0]   MH  = 10'((64'd1 << KH) / HUE_STEPS);
    localparam logic [F:0]   ML  = (F+1)'((64'd1 << (F + 8)) / 255);
    localparam logic [F:0]   MF  = (F+1)'((64'd1 << (F + HW)) / HUE_STEPS);
    localparam logic [F+1:0] K_ONE = (F+2)'(64'd1 << F);
    localparam logic [HW+F-1:0] K_STEPS_HF = (HW+F)'(HUE_STEPS);

    // floor(x * 2^F / 255) from an estimate that is at most one low
    function automatic logic [F:0] fix_div255(input logic [7:0] x, input logic [F:0] q);
        logic [F+8:0] q255;
        logic [F+8:0] rem;
        q255 = {q, 8'h00} - {8'h00, q};
        rem  = {1'b0, x, {F{1'b0}}} - q255;
        return (rem >= (F+9)'(255)) ? q + (F+1)'(1) : q;
    endfunction

    assign busy = 1'b0;

    // ---------------- valid pipeline
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign o_valid = r_vld[LAT-1];

    // ---------------- stage A: reciprocal estimates
    logic [18:0]  w_hq_prod;
    logic [F+8:0] w_lq_prod;
    logic [F+8:0] w_sq_prod;

    logic [8:0] r_a_hue;
    logic [8:0] r_a_q0;
    logic [F:0] r_a_lq;
    logic [F:0] r_a_sq;
    logic [7:0] r_a_lit;
    logic [7:0] r_a_sat;
    logic       r_a_gray;

    assign w_hq_prod = i_request.hue_deg * MH;
    assign w_lq_prod = i_request.lightness * ML;
    assign w_sq_prod = i_request.saturation * ML;

    always_ff @(posedge i_clk) begin
        r_a_hue  <= i_request.hue_deg;
        r_a_q0   <= 9'(w_hq_prod >> KH);
        r_a_lq   <= w_lq_prod[F+8:8];
        r_a_sq   <= w_sq_prod[F+8:8];
        r_a_lit  <= i_request.lightness;
        r_a_sat  <= i_request.saturation;
        r_a_gray <= (i_request.saturation == 8'h00);
    end

    // ---------------- stage B: hue modulo, exact L and S
    logic [21:0]  w_qn;
    logic [8:0]   w_hrem9;
    logic [12:0]  w_hrem13;
    logic [HW-1:0] n_b_r;

    logic [HW-1:0] r_b_r;
    logic [F:0]    r_b_l;
    logic [F:0]    r_b_s;
    logic          r_b_lo;
    logic [7:0]    r_b_lit;
    logic          r_b_gray;

    always_comb begin
        w_qn     = r_a_q0 * N13;
        w_hrem9  = r_a_hue - w_qn[8:0];
        w_hrem13 = {4'h0, w_hrem9};
        n_b_r    = (w_hrem13 >= N13) ? HW'(w_hrem13 - N13) : HW'(w_hrem13);
    end

    always_ff @(posedge i_clk) begin
        r_b_r    <= n_b_r;
        r_b_l    <= fix_div255(r_a_lit, r_a_lq);
        r_b_s    <= fix_div255(r_a_sat, r_a_sq);
        r_b_lo   <= ~r_a_lit[7];
        r_b_lit  <= r_a_lit;
        r_b_gray <= r_a_gray;
    end

    // ---------------- stage C: hue fraction estimate, level product
    logic [F+1:0]   w_sel;
    logic [2*F+2:0] w_p;
    logic [HW+F:0]  w_hf_prod;

    logic [HW-1:0] r_c_r;
    logic [F-1:0]  r_c_hq;
    logic [F+2:0]  r_c_ps;
    logic [F:0]    r_c_l;
    logic [F:0]    r_c_s;
    logic          r_c_lo;
    logic [7:0]    r_c_lit;
    logic          r_c_gray;

    assign w_sel     = r_b_lo ? K_ONE + {1'b0, r_b_s} : {1'b0, r_b_s};
    assign w_p       = r_b_l * w_sel;
    assign w_hf_prod = r_b_r * MF;

    always_ff @(posedge i_clk) begin
        r_c_r    <= r_b_r;
        r_c_hq   <= w_hf_prod[HW+F-1:HW];
        r_c_ps   <= w_p[2*F+2:F];
        r_c_l    <= r_b_l;
        r_c_s    <= r_b_s;
        r_c_lo   <= r_b_lo;
        r_c_lit  <= r_b_lit;
        r_c_gray <= r_b_gray;
    end

    // ---------------- stage D: exact hue fraction, v1 and v2 - v1
    logic [F+12:0]        w_hn;
    logic [HW+F-1:0]      w_hrem;
    logic signed [CW-1:0] w_l;
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] w_ps;
    logic signed [CW-1:0] w_v2;
    logic signed [CW-1:0] w_dd;
    logic [F-1:0]         n_d_h;
    logic signed [CW-1:0] n_d_v1;

    logic [F-1:0]         r_d_h;
    logic signed [CW-1:0] r_d_v1;
    logic [F+1:0]         r_d_d;
    logic [7:0]           r_d_lit;
    logic                 r_d_gray;

    always_comb begin
        w_hn   = r_c_hq * N13;
        w_hrem = {r_c_r, {F{1'b0}}} - w_hn[HW+F-1:0];
        n_d_h  = (w_hrem >= K_STEPS_HF) ? r_c_hq + F'(1) : r_c_hq;
        w_l    = $signed(CW'(r_c_l));
        w_s    = $signed(CW'(r_c_s));
        w_ps   = $signed(CW'(r_c_ps));
        w_v2   = r_c_lo ? w_ps : w_l + w_s - w_ps;
        n_d_v1 = (w_l <<< 1) - w_v2;
        w_dd   = (w_v2 - w_l) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        r_d_h    <= n_d_h;
        r_d_v1   <= n_d_v1;
        r_d_d    <= w_dd[F+1:0];
        r_d_lit  <= r_c_lit;
        r_d_gray <= r_c_gray;
    end

    // ---------------- stages E..H: one unit per channel
    hsl2rgb_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
        .i_clk   (i_clk),
        .i_shift (hsl2rgb_pkg::HUE_SHIFT_UP),
        .i_hue   (r_d_h),
        .i_v1    (r_d_v1),
        .i_d     (r_d_d),
        .i_gray  (r_d_gray),
        .i_lit   (r_d_lit),
        .o_level (o_result.red)
    );

    hsl2rgb_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
        .i_clk   (i_clk),
        .i_shift (hsl2rgb_pkg::HUE_SHIFT_NONE),
        .i_hue   (r_d_h),
        .i_v1    (r_d_v1),
        .i_d     (r_d_d),
        .i_gray  (r_d_gray),
        .i_lit   (r_d_lit),
        .o_level (o_result.green)
    );

    hsl2rgb_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .i_clk   (i_clk),
        .i_shift (hsl2rgb_pkg::HUE_SHIFT_DOWN),
        .i_hue   (r_d_h),
        .i_v1    (r_d_v1),
        .i_d     (r_d_d),
        .i_gray  (r_d_gray),
        .i_lit   (r_d_lit),
        .o_level (o_result.blue)
    );

    // ---------------- checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without request");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && !busy && (i_request.saturation == 8'h00), LAT))
        |-> ((o_result.red == $past(i_request.lightness, LAT)) &&
             (o_result.green == $past(i_request.lightness, LAT)) &&
             (o_result.blue == $past(i_request.lightness, LAT))))
        else $error("gray request did not return lightness");

endmodule
